@@ rtl/deq_pkg.sv @@
// Shared types and codes for the double-ended queue unit.
// Holds the request and response payload structs, mode codes and status codes.
// No dependencies.
`default_nettype none

package deq_pkg;

   // request modes
   localparam logic [2:0] MODE_PUSH_REAR  = 3'd0;
   localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
   localparam logic [2:0] MODE_POP_BACK   = 3'd2;
   localparam logic [2:0] MODE_POP_HEAD   = 3'd3;
   localparam logic [2:0] MODE_READ_INDEX = 3'd4;
   localparam logic [2:0] MODE_CLEAR      = 3'd5;

   // response status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_EMPTY    = 2'd1;
   localparam logic [1:0] STAT_FULL     = 2'd2;
   localparam logic [1:0] STAT_BAD_POS  = 2'd3;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] item_value;
      logic [6:0] position;
   } req_type;

   typedef struct packed {
      logic [7:0] result_value;
      logic [1:0] status;
      logic [7:0] occupancy;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/deq_slot_ram.sv @@
// Slot memory of the double-ended queue: one shared address port,
// synchronous write, read data registered. No dependencies.
`default_nettype none

module deq_slot_ram #(
   parameter int DEPTH = 128,
   parameter int AW    = 7,
   parameter int VW    = 8
) (
   input  wire logic          clock,
   input  wire logic [AW-1:0] addr,
   input  wire logic          wr_en,
   input  wire logic [VW-1:0] wr_data,
   input  wire logic          rd_en,
   output logic      [VW-1:0] rd_data
);

   logic [VW-1:0] mem [DEPTH];
   logic [VW-1:0] rd_data_ff;

   // write a slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   // read a slot into the output register
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/deq_ctrl.sv @@
// Pointer and count control of the double-ended queue: decodes a request,
// updates head and count, drives the slot memory and forms the response.
// Depends on deq_pkg.
`default_nettype none

module deq_ctrl #(
   parameter int DEPTH      = 128,
   parameter int VALUE_BITS = 8,
   parameter int AW         = 7,
   parameter int CW         = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire deq_pkg::req_type      req,
   output logic      [AW-1:0]         mem_addr,
   output logic                       mem_wr_en,
   output logic      [VALUE_BITS-1:0] mem_wr_data,
   output logic                       mem_rd_en,
   output deq_pkg::rsp_type           rsp
);

   localparam int PW = (CW > 7) ? CW : 7;
   localparam logic [AW:0]   DEPTH_S   = (AW+1)'(DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;

   logic          is_full, is_empty, pos_bad;
   logic [AW-1:0] offset, head_dec, ring_addr;
   logic [AW:0]   ring_sum;
   logic [1:0]    status;

   assign is_full  = (count_ff == FULL_CNT);
   assign is_empty = (count_ff == '0);
   assign pos_bad  = (PW'(req.position) >= PW'(count_ff));
   assign head_dec = (head_ff == '0) ? LAST_SLOT : (head_ff - AW'(1));

   // pick the offset from the front that the mode addresses
   always_comb begin
      unique case (req.mode)
         deq_pkg::MODE_PUSH_REAR:  offset = AW'(count_ff);
         deq_pkg::MODE_POP_BACK:   offset = AW'(count_ff - CW'(1));
         deq_pkg::MODE_READ_INDEX: offset = AW'(req.position);
         default:                  offset = '0;
      endcase
   end

   // wrap head plus offset around the ring
   assign ring_sum  = {1'b0, head_ff} + {1'b0, offset};
   assign ring_addr = (ring_sum >= DEPTH_S) ? AW'(ring_sum - DEPTH_S) : AW'(ring_sum);

   // decode the request into state updates and memory access
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status    = deq_pkg::STAT_OK;
      mem_addr  = ring_addr;
      mem_wr_en = 1'b0;
      mem_rd_en = 1'b0;
      unique case (req.mode)
         deq_pkg::MODE_PUSH_REAR: begin
            if (is_full) begin
               status = deq_pkg::STAT_FULL;
            end else begin
               mem_wr_en = accept;
               count_in  = count_ff + CW'(1);
            end
         end
         deq_pkg::MODE_PUSH_FRONT: begin
            mem_addr = head_dec;
            if (is_full) begin
               status = deq_pkg::STAT_FULL;
            end else begin
               mem_wr_en = accept;
               head_in   = head_dec;
               count_in  = count_ff + CW'(1);
            end
         end
         deq_pkg::MODE_POP_BACK: begin
            if (is_empty) begin
               status = deq_pkg::STAT_EMPTY;
            end else begin
               mem_rd_en = accept;
               count_in  = count_ff - CW'(1);
            end
         end
         deq_pkg::MODE_POP_HEAD: begin
            mem_addr = head_ff;
            if (is_empty) begin
               status = deq_pkg::STAT_EMPTY;
            end else begin
               mem_rd_en = accept;
               head_in   = (head_ff == LAST_SLOT) ? '0 : (head_ff + AW'(1));
               count_in  = count_ff - CW'(1);
            end
         end
         deq_pkg::MODE_READ_INDEX: begin
            if (pos_bad) begin
               status = deq_pkg::STAT_BAD_POS;
            end else begin
               mem_rd_en = accept;
            end
         end
         deq_pkg::MODE_CLEAR: begin
            head_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign mem_wr_data = VALUE_BITS'(req.item_value);

   // value stays zero here; popped and read values arrive from memory later
   assign rsp.result_value = '0;
   assign rsp.status       = status;
   assign rsp.occupancy    = 8'(count_in);

   // advance head and count on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count exceeds depth");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("memory read and write in the same cycle");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LAST_SLOT)
      else $error("head pointer outside the ring");

endmodule

`default_nettype wire

@@ rtl/double_ended_queue_unit.sv @@
// Double-ended queue unit: a bounded deque of small items held in a ring buffer
// in one synchronous slot memory, addressed by a head pointer and an item count.
//
// Request channel (req_valid/req_stall/req_data): one request per item, mode
// selects push back, push front, pop back, pop front, read at a position from
// the front, or clear. Response channel (rsp_valid/rsp_stall/rsp_data): exactly
// one response per request, in order, with value, status and occupancy.
//
// Timing: pushes, clear, refused and unused requests produce a response in the
// cycle after acceptance and allow one request per cycle unless the response
// stalls. Pops and reads that hit the memory go through the slot memory read
// register first, and the next request is held off during that read.
//
// Reset (synchronous, active high) empties the queue and drops any pending
// response; slot contents are not cleared and need no clearing pass.
// When the receiver stalls, the response register holds its payload and the
// unit stalls new requests until the response is taken; a request is still
// accepted in the cycle the waiting response is taken.
// Depends on deq_pkg, deq_ctrl and deq_slot_ram.
`default_nettype none

module double_ended_queue_unit #(
   parameter int DEPTH      = 128,
   parameter int VALUE_BITS = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire deq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output deq_pkg::rsp_type      rsp_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic                  req_accept, rsp_take;
   logic [AW-1:0]         mem_addr;
   logic                  mem_wr_en, mem_rd_en;
   logic [VALUE_BITS-1:0] mem_wr_data, mem_rd_data;
   deq_pkg::rsp_type      ctrl_rsp;

   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   deq_pkg::rsp_type rsp_ff, rsp_in;

   // hold requests during a memory read and while a response is stalled
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign req_stall  = pend_ff || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   deq_ctrl #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS),
      .AW         (AW),
      .CW         (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .req         (req_data),
      .mem_addr    (mem_addr),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .rsp         (ctrl_rsp)
   );

   deq_slot_ram #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .VW    (VALUE_BITS)
   ) u_slot_ram (
      .clock   (clock),
      .addr    (mem_addr),
      .wr_en   (mem_wr_en),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_data (mem_rd_data)
   );

   // load the response register at accept, patch in read data on the following cycle
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      pend_in      = 1'b0;
      if (req_accept) begin
         rsp_in       = ctrl_rsp;
         rsp_valid_in = !mem_rd_en;
         pend_in      = mem_rd_en;
      end else if (pend_ff) begin
         rsp_in.result_value = 8'(mem_rd_data);
         rsp_valid_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_pend_no_rsp: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !rsp_valid_ff)
      else $error("response shown while memory read is pending");

   a_pend_completes: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> rsp_valid_ff && !pend_ff)
      else $error("memory read did not complete into the response");

   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !req_accept)
      else $error("request accepted during a memory read");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for double_ended_queue_unit: drives requests on the
// valid/stall channel, predicts every response with a ring-buffer mirror of the
// queue and compares value, status and occupancy in order. Depends on deq_pkg.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         QDEPTH      = 128;
   localparam logic [7:0] FULL_COUNT  = 8'd128;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         PRINT_CAP   = 200;

   // modes the unit must ignore
   localparam logic [2:0] MODE_SPARE_6 = 3'd6;
   localparam logic [2:0] MODE_SPARE_7 = 3'd7;

   typedef enum {TILT_GROW, TILT_MIXED, TILT_SHRINK} tilt_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   deq_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   deq_pkg::rsp_type rsp_data;

   // mirror of the queue contents
   logic [7:0] slot_mirror [QDEPTH];
   logic [6:0] front_idx  = '0;
   logic [7:0] held_count = '0;

   deq_pkg::rsp_type expected_rsp_q [$];

   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int drain_hold  = 0;

   int requests_sent = 0;
   int rsp_checked   = 0;
   int mismatches    = 0;
   int status_seen [4] = '{0, 0, 0, 0};
   int cycle_count   = 0;

   double_ended_queue_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still due",
                  cycle_count, expected_rsp_q.size());
         $display("tb_top failed");
         $finish;
      end
   end

   // Apply one request to the mirror and return the response it must produce.
   function automatic deq_pkg::rsp_type apply_deque_op(input deq_pkg::req_type r);
      deq_pkg::rsp_type o;
      logic [6:0]       idx;
      o = '0;
      case (r.mode)
         deq_pkg::MODE_PUSH_REAR: begin
            if (held_count == FULL_COUNT) begin
               o.status = deq_pkg::STAT_FULL;
            end else begin
               idx = front_idx + held_count[6:0];
               slot_mirror[idx] = r.item_value;
               held_count++;
            end
         end
         deq_pkg::MODE_PUSH_FRONT: begin
            if (held_count == FULL_COUNT) begin
               o.status = deq_pkg::STAT_FULL;
            end else begin
               front_idx = front_idx - 7'd1;
               slot_mirror[front_idx] = r.item_value;
               held_count++;
            end
         end
         deq_pkg::MODE_POP_BACK: begin
            if (held_count == 8'd0) begin
               o.status = deq_pkg::STAT_EMPTY;
            end else begin
               idx = front_idx + held_count[6:0] - 7'd1;
               o.result_value = slot_mirror[idx];
               held_count--;
            end
         end
         deq_pkg::MODE_POP_HEAD: begin
            if (held_count == 8'd0) begin
               o.status = deq_pkg::STAT_EMPTY;
            end else begin
               o.result_value = slot_mirror[front_idx];
               front_idx = front_idx + 7'd1;
               held_count--;
            end
         end
         deq_pkg::MODE_READ_INDEX: begin
            if ({1'b0, r.position} >= held_count) begin
               o.status = deq_pkg::STAT_BAD_POS;
            end else begin
               idx = front_idx + r.position;
               o.result_value = slot_mirror[idx];
            end
         end
         deq_pkg::MODE_CLEAR: begin
            front_idx  = '0;
            held_count = '0;
         end
         default: begin
         end
      endcase
      o.occupancy = held_count;
      return o;
   endfunction

   // Offer one request after a random gap, hold it until accepted, then predict.
   task automatic send_request(input logic [2:0] mode, input logic [7:0] value,
                               input logic [6:0] pos);
      deq_pkg::req_type r;
      int               gap;
      r.mode       = mode;
      r.item_value = value;
      r.position   = pos;
      gap = req_idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      expected_rsp_q = {expected_rsp_q, apply_deque_op(r)};
      requests_sent++;
   endtask

   // Pick a read position, mostly inside the occupied range.
   function automatic logic [6:0] pick_position();
      if (held_count != 8'd0 && $urandom_range(0, 99) < 85)
         return 7'($urandom_range(int'(held_count) - 1, 0));
      return 7'($urandom_range(0, QDEPTH - 1));
   endfunction

   // Send one random request, weighted toward growing or shrinking the queue.
   task automatic send_random_request(input tilt_type tilt);
      int         roll;
      int         push_pct;
      int         pop_pct;
      logic [2:0] m;
      roll     = $urandom_range(0, 99);
      push_pct = (tilt == TILT_GROW) ? 60 : (tilt == TILT_MIXED) ? 38 : 18;
      pop_pct  = (tilt == TILT_SHRINK) ? 60 : (tilt == TILT_MIXED) ? 38 : 18;
      if (roll < push_pct)
         m = $urandom_range(0, 1) ? deq_pkg::MODE_PUSH_FRONT : deq_pkg::MODE_PUSH_REAR;
      else if (roll < push_pct + pop_pct)
         m = $urandom_range(0, 1) ? deq_pkg::MODE_POP_HEAD : deq_pkg::MODE_POP_BACK;
      else if (roll == 97 && tilt == TILT_MIXED)
         m = deq_pkg::MODE_CLEAR;
      else if (roll == 98)
         m = MODE_SPARE_6;
      else if (roll == 99)
         m = MODE_SPARE_7;
      else
         m = deq_pkg::MODE_READ_INDEX;
      send_request(m, 8'($urandom), (m == deq_pkg::MODE_READ_INDEX) ? pick_position()
                                                                     : 7'($urandom));
   endtask

   // Pops, reads, clear and ignored modes on an empty queue.
   task automatic test_empty_queue();
      send_request(deq_pkg::MODE_POP_BACK,   8'hFF, 7'd0);
      send_request(deq_pkg::MODE_POP_HEAD,   8'h00, 7'd127);
      send_request(deq_pkg::MODE_READ_INDEX, 8'h00, 7'd0);
      send_request(deq_pkg::MODE_READ_INDEX, 8'hFF, 7'd127);
      send_request(deq_pkg::MODE_CLEAR,      8'h00, 7'd0);
      send_request(MODE_SPARE_6,             8'($urandom), 7'($urandom));
      send_request(MODE_SPARE_7,             8'($urandom), 7'($urandom));
   endtask

   // Every mode on a small queue, with field extremes.
   task automatic test_every_mode();
      send_request(deq_pkg::MODE_PUSH_REAR,  8'h00, 7'd127);
      send_request(deq_pkg::MODE_PUSH_REAR,  8'hFF, 7'd0);
      send_request(deq_pkg::MODE_PUSH_FRONT, 8'h5A, 7'd0);
      send_request(deq_pkg::MODE_PUSH_FRONT, 8'hA5, 7'd127);
      send_request(deq_pkg::MODE_READ_INDEX, 8'h00, 7'd0);
      send_request(deq_pkg::MODE_READ_INDEX, 8'h00, 7'd3);
      send_request(deq_pkg::MODE_READ_INDEX, 8'h00, 7'd4);
      send_request(deq_pkg::MODE_READ_INDEX, 8'h00, 7'd127);
      send_request(MODE_SPARE_6,             8'hFF, 7'd127);
      send_request(MODE_SPARE_7,             8'h00, 7'd0);
      send_request(deq_pkg::MODE_POP_HEAD,   8'h00, 7'd0);
      send_request(deq_pkg::MODE_POP_BACK,   8'h00, 7'd0);
      send_request(deq_pkg::MODE_CLEAR,      8'hFF, 7'd127);
      send_request(deq_pkg::MODE_POP_HEAD,   8'h00, 7'd0);
      send_request(deq_pkg::MODE_PUSH_FRONT, 8'h81, 7'd0);
      send_request(deq_pkg::MODE_POP_BACK,   8'h00, 7'd0);
   endtask

   // Fill to capacity from both ends, hit the refusals, then drain to empty.
   task automatic test_fill_and_drain();
      send_request(deq_pkg::MODE_CLEAR, 8'h00, 7'd0);
      while (held_count != FULL_COUNT)
         send_request($urandom_range(0, 1) ? deq_pkg::MODE_PUSH_FRONT
                                           : deq_pkg::MODE_PUSH_REAR,
                      8'($urandom), 7'($urandom));
      send_request(deq_pkg::MODE_PUSH_REAR,  8'hFF, 7'd0);
      send_request(deq_pkg::MODE_PUSH_FRONT, 8'h00, 7'd127);
      send_request(deq_pkg::MODE_READ_INDEX, 8'h00, 7'd127);
      send_request(deq_pkg::MODE_READ_INDEX, 8'hFF, 7'd0);
      send_request(MODE_SPARE_7,             8'($urandom), 7'($urandom));
      while (held_count != 8'd0) begin
         if ($urandom_range(0, 4) == 0)
            send_request(deq_pkg::MODE_READ_INDEX, 8'($urandom), pick_position());
         else
            send_request($urandom_range(0, 1) ? deq_pkg::MODE_POP_HEAD
                                              : deq_pkg::MODE_POP_BACK,
                         8'($urandom), 7'($urandom));
      end
      send_request(deq_pkg::MODE_POP_BACK, 8'h00, 7'd0);
   endtask

   // Hold the response side for a long stretch while requests keep coming.
   task automatic test_output_backpressure();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      drain_hold  = 100;
      repeat (40) send_random_request(TILT_MIXED);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // Random phases that push the queue toward full and back toward empty.
   task automatic test_random_traffic(input int phases);
      tilt_type tilt;
      for (int p = 0; p < phases; p++) begin
         tilt = (p % 6 < 3) ? TILT_GROW : (p % 6 == 3) ? TILT_MIXED : TILT_SHRINK;
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         repeat (100) send_random_request(tilt);
      end
   endtask

   // Response side: random stall per response, plus the long hold on request.
   initial begin : response_side
      int wait_cycles;
      while (reset) @(posedge clock);
      forever begin
         if (drain_hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (drain_hold) @(posedge clock);
            drain_hold = 0;
         end
         wait_cycles = rsp_idle_on ? $urandom_range(0, 7) : 0;
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic compare_field(input string label, input int want, input int got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= PRINT_CAP)
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, label, want, got);
      end
   endtask

   // Check every accepted response against the oldest prediction.
   always @(posedge clock) begin
      deq_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            mismatches++;
            $display("%0t ns: response with none expected, expected nothing, actual %h",
                     $time, rsp_data);
         end else begin
            want = expected_rsp_q[0];
            expected_rsp_q.delete(0);
            compare_field("result_value", want.result_value, rsp_data.result_value);
            compare_field("status", want.status, rsp_data.status);
            compare_field("occupancy", want.occupancy, rsp_data.occupancy);
            status_seen[want.status]++;
            rsp_checked++;
         end
      end
   end

   initial begin : main_sequence
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue();
      test_every_mode();
      test_fill_and_drain();
      test_output_backpressure();
      test_random_traffic(13);
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("%0d requests sent, %0d responses checked, %0d mismatches",
               requests_sent, rsp_checked, mismatches);
      $display("status mix: %0d ok, %0d empty, %0d full, %0d bad position",
               status_seen[deq_pkg::STAT_OK], status_seen[deq_pkg::STAT_EMPTY],
               status_seen[deq_pkg::STAT_FULL], status_seen[deq_pkg::STAT_BAD_POS]);
      if (mismatches == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
